// ----- sv/wsm_pkg.sv -----
// Shared types, codes and constants of the walk state moments block.
package wsm_pkg;

   // default store depth in sites
   localparam int MAX_SITES_DEF = 4096;

   // restoring division of a distance sum by the walk step
   localparam int DIST_W     = 56;
   localparam int DIV_STEPS  = DIST_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_SIZE  = 2'd1;
   localparam logic [1:0] STATUS_STEP_ZERO = 2'd2;
   localparam logic [1:0] STATUS_MISMATCH  = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_LINE_MODE  = 2'd0;
   localparam logic [1:0] CSR_SITE_LIMIT = 2'd1;
   localparam logic [1:0] CSR_MIXING     = 2'd2;
   localparam logic [1:0] CSR_UNIFORM    = 2'd3;

   // controller states
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CHECK,
      ST_CLEAR,
      ST_SQ,
      ST_MUL,
      ST_MUL2,
      ST_ACC,
      ST_MEAN,
      ST_MSQ,
      ST_DIV,
      ST_OUT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       clr_wr;
      logic       sq;
      logic [1:0] sq_sel;
      logic       mul;
      logic       mul2;
      logic       acc;
      logic       mean;
      logic       msq;
      logic       div_step;
      logic       out_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic need_clear;
      logic last;
      logic out_free;
   } stat_type;

endpackage

// ----- sv/wsm_ctrl.sv -----
// Controller state machine: sequences each transaction through the datapath.
module wsm_ctrl
   import wsm_pkg::*;
#(
   parameter int MAX_SITES = MAX_SITES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  stat_type                     stat,
   output cmd_type                      cmd,
   output logic [$clog2(MAX_SITES)-1:0] clr_addr
);

   localparam int IDX_W = $clog2(MAX_SITES);

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       sweep_ff, sweep_in;
   logic [1:0]             sq_cnt_ff, sq_cnt_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   sweep_last;
   logic                   div_last;

   assign sweep_last = (sweep_ff == IDX_W'(MAX_SITES - 1));
   assign div_last   = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT:  if (sweep_last) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_CHECK;
         ST_CHECK: state_in = stat.need_clear ? ST_CLEAR : ST_SQ;
         ST_CLEAR: if (sweep_last) state_in = ST_SQ;
         ST_SQ:    if (sq_cnt_ff == 2'd3) state_in = ST_MUL;
         ST_MUL:   state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_ACC;
         ST_ACC:   state_in = stat.last ? ST_MEAN : ST_IDLE;
         ST_MEAN:  state_in = ST_MSQ;
         ST_MSQ:   state_in = ST_DIV;
         ST_DIV:   if (div_last) state_in = ST_OUT;
         ST_OUT:   if (stat.out_free) state_in = ST_IDLE;
         default:  state_in = ST_INIT;
      endcase
   end

   // advance the sweep, square and division counters
   always_comb begin
      sweep_in   = '0;
      sq_cnt_in  = '0;
      div_cnt_in = '0;
      if ((state_ff == ST_INIT || state_ff == ST_CLEAR) && !sweep_last) begin
         sweep_in = sweep_ff + 1'b1;
      end
      if (state_ff == ST_SQ) begin
         sq_cnt_in = sq_cnt_ff + 1'b1;
      end
      if (state_ff == ST_DIV) begin
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_INIT:  cmd.clr_wr = 1'b1;
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_CHECK: cmd = '0;
         ST_CLEAR: cmd.clr_wr = 1'b1;
         ST_SQ: begin
            cmd.sq     = 1'b1;
            cmd.sq_sel = sq_cnt_ff;
         end
         ST_MUL:   cmd.mul      = 1'b1;
         ST_MUL2:  cmd.mul2     = 1'b1;
         ST_ACC:   cmd.acc      = 1'b1;
         ST_MEAN:  cmd.mean     = 1'b1;
         ST_MSQ:   cmd.msq      = 1'b1;
         ST_DIV:   cmd.div_step = 1'b1;
         ST_OUT:   cmd.out_load = stat.out_free;
         default:  cmd = '0;
      endcase
   end

   assign clr_addr = sweep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         sweep_ff   <= '0;
         sq_cnt_ff  <= '0;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         sweep_ff   <= sweep_in;
         sq_cnt_ff  <= sq_cnt_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

// ----- sv/wsm_datapath.sv -----
// Datapath: configuration, per-site arithmetic, probability store and result register.
module wsm_datapath
   import wsm_pkg::*;
#(
   parameter int MAX_SITES = MAX_SITES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [1:0]                   csr_index,
   input  logic [31:0]                  csr_wdata,
   input  logic signed [15:0]           req_amp0_re,
   input  logic signed [15:0]           req_amp0_im,
   input  logic signed [15:0]           req_amp1_re,
   input  logic signed [15:0]           req_amp1_im,
   input  logic [15:0]                  req_stationary_prob,
   input  logic [15:0]                  req_walk_step,
   input  logic                         req_last_site,
   input  cmd_type                      cmd,
   input  logic [$clog2(MAX_SITES)-1:0] clr_addr,
   output stat_type                     stat,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [15:0]                  rsp_step_echo,
   output logic signed [31:0]           rsp_mean_position,
   output logic signed [43:0]           rsp_position_variance,
   output logic [32:0]                  rsp_tvd_stationary,
   output logic [32:0]                  rsp_tvd_uniform
);

   localparam int IDX_W   = $clog2(MAX_SITES);
   localparam int CNT_W   = $clog2(MAX_SITES + 1);
   localparam int POS_W   = ((IDX_W > 11) ? IDX_W : 11) + 2;
   localparam int APOS_W  = POS_W - 1;
   localparam int SQ2_W   = 2 * APOS_W;
   localparam int P30_W   = 33;
   localparam int P20_W   = 23;
   localparam int PP_W    = POS_W + P20_W + 1;
   localparam int SEC_W   = SQ2_W + P20_W;
   localparam int CMP_W   = ((CNT_W > 12) ? CNT_W : 12) + 1;

   // configuration
   logic        line_mode_ff;
   logic [10:0] site_limit_ff;
   logic        mixing_ff;
   logic [31:0] uniform_ff;

   // captured transaction
   logic signed [15:0] a0r_ff, a0i_ff, a1r_ff, a1i_ff;
   logic [15:0]        stat_ff, step_ff;
   logic               last_ff;

   // per-site working registers
   logic [P30_W-1:0]        p30_ff;
   logic [47:0]             rd_ff;
   logic signed [PP_W-1:0]  pos_prod_ff;
   logic [SQ2_W-1:0]        apos2_ff;
   logic [SEC_W-1:0]        sec_prod_ff;
   logic [47:0]             s_ff;
   logic [45:0]             ps_ff, pu_ff;

   // pass accumulators
   logic [CNT_W-1:0]        cnt_ff;
   logic                    extra_ff;
   logic signed [47:0]      first_ff;
   logic [55:0]             second_ff;
   logic [DIST_W-1:0]       dist_s_ff, dist_u_ff;

   // pass end registers
   logic [1:0]              status_ff;
   logic signed [31:0]      mean_ff;
   logic [63:0]             msq_ff;
   logic [DIST_W-1:0]       qs_ff, qu_ff;
   logic [16:0]             rs_ff, ru_ff;

   // result register
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_status_ff;
   logic [15:0]             rsp_step_ff;
   logic signed [31:0]      rsp_mean_ff;
   logic signed [43:0]      rsp_var_ff;
   logic [32:0]             rsp_tvd_s_ff, rsp_tvd_u_ff;

   // probability sum store
   logic [47:0] mem [MAX_SITES];

   logic [IDX_W-1:0]        idx;
   logic                    in_range;
   logic                    mix_act;
   logic signed [15:0]      sq_op;
   logic signed [31:0]      sq_val;
   logic [P30_W-1:0]        p30_in;
   logic [P20_W-1:0]        p20;
   logic signed [POS_W-1:0] pos;
   logic [APOS_W-1:0]       apos;
   logic [48:0]             s_sum;
   logic [48:0]             first_sum;
   logic [57:0]             second_sum;
   logic [47:0]             d_s, d_u;
   logic [DIST_W:0]         dist_s_sum, dist_u_sum;
   logic [11:0]             expected;
   logic                    bad_size, mismatch, step_zero;
   logic [31:0]             am;
   logic [16:0]             rs_in, ru_in;
   logic [DIST_W-1:0]       qs_in, qu_in;
   logic signed [57:0]      var_diff;
   logic signed [43:0]      var_val;
   logic [32:0]             tvd_s, tvd_u;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_wa;
   logic [47:0]             mem_wd;

   // one restoring division step: returns {remainder, quotient}
   function automatic logic [16+DIST_W:0] div_bit(input logic [16:0] r,
                                                 input logic [DIST_W-1:0] q,
                                                 input logic [15:0] d);
      logic [16:0] sh;
      logic        ge;
      sh = {r[15:0], q[DIST_W-1]};
      ge = (sh >= {1'b0, d});
      return {(ge ? sh - {1'b0, d} : sh), q[DIST_W-2:0], ge};
   endfunction

   function automatic logic [47:0] abs_diff48(input logic [47:0] a, input logic [47:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   assign idx      = cnt_ff[IDX_W-1:0];
   assign in_range = (cnt_ff < CNT_W'(MAX_SITES));
   assign mix_act  = mixing_ff && (step_ff != 16'd0);

   assign stat.need_clear = mixing_ff && (step_ff == 16'd1) && (cnt_ff == '0);
   assign stat.last       = last_ff;
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   // sum of squares, one amplitude a cycle
   always_comb begin
      case (cmd.sq_sel)
         2'd0:    sq_op = a0r_ff;
         2'd1:    sq_op = a0i_ff;
         2'd2:    sq_op = a1r_ff;
         default: sq_op = a1i_ff;
      endcase
      sq_val = sq_op * sq_op;
      p30_in = ((cmd.sq_sel == 2'd0) ? '0 : p30_ff) + P30_W'($unsigned(sq_val));
   end

   // position, its magnitude and the store sum before saturation
   always_comb begin
      p20   = p30_ff[P30_W-1:10];
      pos   = $signed(POS_W'(idx)) - $signed(POS_W'(line_mode_ff ? site_limit_ff : 11'd0));
      apos  = pos[POS_W-1] ? APOS_W'(-pos) : APOS_W'(pos);
      s_sum = {1'b0, rd_ff} + 49'(p30_ff);
   end

   // saturating accumulation
   always_comb begin
      first_sum  = {first_ff[47], first_ff} + 49'(pos_prod_ff);
      second_sum = 58'(second_ff) + 58'(sec_prod_ff);
      d_s        = abs_diff48(48'(ps_ff), s_ff);
      d_u        = abs_diff48(48'(pu_ff), s_ff);
      dist_s_sum = {1'b0, dist_s_ff} + (DIST_W + 1)'(d_s);
      dist_u_sum = {1'b0, dist_u_ff} + (DIST_W + 1)'(d_u);
   end

   // status at the pass end
   always_comb begin
      expected  = line_mode_ff ? {site_limit_ff, 1'b1} : {1'b0, site_limit_ff};
      bad_size  = (site_limit_ff == 11'd0) || (CMP_W'(expected) > CMP_W'(MAX_SITES));
      mismatch  = extra_ff || (CMP_W'(cnt_ff) != CMP_W'(expected));
      step_zero = mixing_ff && (step_ff == 16'd0);
      am        = mean_ff[31] ? 32'(-mean_ff) : 32'(mean_ff);
   end

   // division steps and result shaping
   always_comb begin
      {rs_in, qs_in} = div_bit(rs_ff, qs_ff, step_ff);
      {ru_in, qu_in} = div_bit(ru_ff, qu_ff, step_ff);
      var_diff = $signed({2'b00, second_ff}) - $signed(58'(msq_ff[63:20]));
      if (var_diff[57:43] != {15{var_diff[57]}}) begin
         var_val = var_diff[57] ? {1'b1, 43'd0} : {1'b0, {43{1'b1}}};
      end else begin
         var_val = var_diff[43:0];
      end
      tvd_s = (|qs_ff[DIST_W-1:33]) ? {33{1'b1}} : qs_ff[32:0];
      tvd_u = (|qu_ff[DIST_W-1:33]) ? {33{1'b1}} : qu_ff[32:0];
   end

   // store write: clearing sweep or updated sum
   always_comb begin
      mem_we = cmd.clr_wr || (cmd.acc && in_range && mix_act);
      mem_wa = cmd.clr_wr ? clr_addr : idx;
      mem_wd = cmd.clr_wr ? 48'd0 : s_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[idx];
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         line_mode_ff  <= 1'b1;
         site_limit_ff <= 11'd1;
         mixing_ff     <= 1'b0;
         uniform_ff    <= 32'hFFFF_FFFF;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LINE_MODE:  line_mode_ff  <= csr_wdata[0];
            CSR_SITE_LIMIT: site_limit_ff <= csr_wdata[10:0];
            CSR_MIXING:     mixing_ff     <= csr_wdata[0];
            CSR_UNIFORM:    uniform_ff    <= csr_wdata;
            default:        mixing_ff     <= mixing_ff;
         endcase
      end
   end

   // capture the transaction and run the per-site stages
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a0r_ff  <= req_amp0_re;
         a0i_ff  <= req_amp0_im;
         a1r_ff  <= req_amp1_re;
         a1i_ff  <= req_amp1_im;
         stat_ff <= req_stationary_prob;
         step_ff <= req_walk_step;
         last_ff <= req_last_site;
      end
      if (cmd.sq) begin
         p30_ff <= p30_in;
      end
      if (cmd.mul) begin
         pos_prod_ff <= PP_W'(pos * $signed({1'b0, p20}));
         apos2_ff    <= apos * apos;
         s_ff        <= s_sum[48] ? {48{1'b1}} : s_sum[47:0];
         ps_ff       <= {stat_ff, 14'd0} * step_ff;
         pu_ff       <= uniform_ff[31:2] * step_ff;
      end
      if (cmd.mul2) begin
         sec_prod_ff <= apos2_ff * p20;
      end
      if (cmd.mean) begin
         if (bad_size) begin
            status_ff <= STATUS_BAD_SIZE;
         end else if (mismatch) begin
            status_ff <= STATUS_MISMATCH;
         end else if (step_zero) begin
            status_ff <= STATUS_STEP_ZERO;
         end else begin
            status_ff <= STATUS_OK;
         end
         if (first_ff[47:31] != {17{first_ff[47]}}) begin
            mean_ff <= first_ff[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         end else begin
            mean_ff <= first_ff[31:0];
         end
         qs_ff <= dist_s_ff;
         qu_ff <= dist_u_ff;
         rs_ff <= '0;
         ru_ff <= '0;
      end
      if (cmd.msq) begin
         msq_ff <= am * am;
      end
      if (cmd.div_step) begin
         qs_ff <= qs_in;
         qu_ff <= qu_in;
         rs_ff <= rs_in;
         ru_ff <= ru_in;
      end
   end

   // pass accumulators: update per site, drop at the pass end
   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         cnt_ff    <= '0;
         extra_ff  <= 1'b0;
         first_ff  <= '0;
         second_ff <= '0;
         dist_s_ff <= '0;
         dist_u_ff <= '0;
      end else if (cmd.acc) begin
         if (in_range) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (first_sum[48] != first_sum[47]) begin
               first_ff <= first_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            end else begin
               first_ff <= first_sum[47:0];
            end
            second_ff <= (|second_sum[57:56]) ? {56{1'b1}} : second_sum[55:0];
            if (mix_act) begin
               dist_s_ff <= dist_s_sum[DIST_W] ? {DIST_W{1'b1}} : dist_s_sum[DIST_W-1:0];
               dist_u_ff <= dist_u_sum[DIST_W] ? {DIST_W{1'b1}} : dist_u_sum[DIST_W-1:0];
            end
         end else begin
            extra_ff <= 1'b1;
         end
      end
   end

   // result register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= status_ff;
         rsp_step_ff   <= step_ff;
         if (status_ff == STATUS_OK) begin
            rsp_mean_ff  <= mean_ff;
            rsp_var_ff   <= var_val;
            rsp_tvd_s_ff <= mixing_ff ? tvd_s : 33'd0;
            rsp_tvd_u_ff <= mixing_ff ? tvd_u : 33'd0;
         end else begin
            rsp_mean_ff  <= '0;
            rsp_var_ff   <= '0;
            rsp_tvd_s_ff <= '0;
            rsp_tvd_u_ff <= '0;
         end
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_step_echo         = rsp_step_ff;
   assign rsp_mean_position     = rsp_mean_ff;
   assign rsp_position_variance = rsp_var_ff;
   assign rsp_tvd_stationary    = rsp_tvd_s_ff;
   assign rsp_tvd_uniform       = rsp_tvd_u_ff;

endmodule

// ----- sv/walk_state_moments_1d.sv -----
// Top level of the 1-D walk state moments block.
// Sites enter on the req_ channel in ascending index order, one transaction
// per site; req_last_site closes a pass. Only the last site of a pass yields
// a transaction on the rsp_ channel: status, step, mean, variance and the two
// distances. Registers are to be written on the csr_ port only while the
// block is idle; the block itself does not enforce this. A site is not
// taken before the previous one is through: a check state, the squaring
// states on the shared multiplier, the product states and an accumulate
// state, then the idle state that takes the next site. A last site then
// passes the mean and mean-square states, the bit-serial division of the
// distance sums by the walk step and the output state. A site that starts
// a pass at walk step one with mixing on first clears the probability
// store, one entry a cycle. After reset the same clearing pass runs over
// the whole store with req_stall high; csr_ writes are taken meanwhile.
// The result sits in an output register; while rsp_stall is high it holds,
// sites of the next pass keep flowing, and only the next pass end waits.
module walk_state_moments_1d
   import wsm_pkg::*;
#(
   parameter int MAX_SITES = MAX_SITES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_amp0_re,
   input  logic signed [15:0] req_amp0_im,
   input  logic signed [15:0] req_amp1_re,
   input  logic signed [15:0] req_amp1_im,
   input  logic [15:0]        req_stationary_prob,
   input  logic [15:0]        req_walk_step,
   input  logic               req_last_site,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_step_echo,
   output logic signed [31:0] rsp_mean_position,
   output logic signed [43:0] rsp_position_variance,
   output logic [32:0]        rsp_tvd_stationary,
   output logic [32:0]        rsp_tvd_uniform
);

   cmd_type                      cmd;
   stat_type                     stat;
   logic [$clog2(MAX_SITES)-1:0] clr_addr;

   wsm_ctrl #(
      .MAX_SITES(MAX_SITES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat     (stat),
      .cmd      (cmd),
      .clr_addr (clr_addr)
   );

   wsm_datapath #(
      .MAX_SITES(MAX_SITES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_amp0_re          (req_amp0_re),
      .req_amp0_im          (req_amp0_im),
      .req_amp1_re          (req_amp1_re),
      .req_amp1_im          (req_amp1_im),
      .req_stationary_prob  (req_stationary_prob),
      .req_walk_step        (req_walk_step),
      .req_last_site        (req_last_site),
      .cmd                  (cmd),
      .clr_addr             (clr_addr),
      .stat                 (stat),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_step_echo        (rsp_step_echo),
      .rsp_mean_position    (rsp_mean_position),
      .rsp_position_variance(rsp_position_variance),
      .rsp_tvd_stationary   (rsp_tvd_stationary),
      .rsp_tvd_uniform      (rsp_tvd_uniform)
   );

endmodule

// ----- sv/wsm_checker.sv -----
// Port-level checker of the walk state moments block and its bind.
module wsm_checker
   import wsm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_mean_position,
   input logic signed [43:0] rsp_position_variance,
   input logic [32:0]        rsp_tvd_stationary,
   input logic [32:0]        rsp_tvd_uniform
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mean_position)
                                 && $stable(rsp_status))
      else $error("stalled result changed");

   // an error result carries no numbers
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |->
         (rsp_mean_position == '0) && (rsp_position_variance == '0)
         && (rsp_tvd_stationary == '0) && (rsp_tvd_uniform == '0))
      else $error("error result with nonzero fields");

   // the store clears after reset before any site is taken
   a_init_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("site taken during the clearing pass");

   // one site at a time
   a_one_site: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second site taken back to back");

endmodule

bind walk_state_moments_1d wsm_checker u_wsm_checker (.*);

// ----- sim/walk_moments_checker.sv -----
// Checker of the walk state moments block: predicts each pass result and compares it.
module walk_moments_checker
   import wsm_pkg::*;
#(
   parameter int MAX_SITES = MAX_SITES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_amp0_re,
   input  logic signed [15:0] req_amp0_im,
   input  logic signed [15:0] req_amp1_re,
   input  logic signed [15:0] req_amp1_im,
   input  logic [15:0]        req_stationary_prob,
   input  logic [15:0]        req_walk_step,
   input  logic               req_last_site,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_status,
   input  logic [15:0]        rsp_step_echo,
   input  logic signed [31:0] rsp_mean_position,
   input  logic signed [43:0] rsp_position_variance,
   input  logic [32:0]        rsp_tvd_stationary,
   input  logic [32:0]        rsp_tvd_uniform,
   output int                 fail_count,
   output int                 results_owed
);

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        step;
      logic signed [31:0] mean;
      logic signed [43:0] variance;
      logic [32:0]        tvd_stat;
      logic [32:0]        tvd_unif;
   } moments_type;

   // register copies
   bit        cfg_line;
   bit [10:0] cfg_limit;
   bit        cfg_mix;
   bit [31:0] cfg_uniform;

   // pass state
   int unsigned       sites_seen;
   bit                overflow_sites;
   longint            first_acc;
   longint unsigned   second_acc;
   longint unsigned   stat_dist_acc;
   longint unsigned   unif_dist_acc;
   longint unsigned   prob_sums [MAX_SITES];
   moments_type       owed_moments [$];

   function automatic longint clamp_s(longint v, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
   endfunction

   function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                               int bits);
      longint unsigned lim;
      lim = (64'd1 << bits) - 1;
      return (a + b > lim) ? lim : a + b;
   endfunction

   // fold one site into the pass; return 1 with the pass result on a last site
   function automatic bit fold_site(input logic signed [15:0] a0r, a0i, a1r, a1i,
                                    input logic [15:0] stat, step, input logic last,
                                    output moments_type res);
      longint          p30, p20, pos, mean, var_v;
      longint unsigned apos, s, ps, pu, am, msq, lim33, tvd_s, tvd_u;
      int unsigned     lattice;
      logic [1:0]      st;
      p30 = longint'(a0r) * a0r + longint'(a0i) * a0i + longint'(a1r) * a1r
            + longint'(a1i) * a1i;
      res = '0;
      if (sites_seen < MAX_SITES) begin
         pos = cfg_line ? longint'(sites_seen) - longint'(cfg_limit) : longint'(sites_seen);
         apos = pos < 0 ? -pos : pos;
         p20 = p30 >>> 10;
         first_acc = clamp_s(first_acc + pos * p20, 48);
         second_acc = sat_add(second_acc, apos * apos * longint'(p20), 56);
         if (cfg_mix && step != 0) begin
            // walk restart wipes the running sums
            if (step == 1 && sites_seen == 0)
               foreach (prob_sums[i]) prob_sums[i] = 0;
            s = sat_add(prob_sums[sites_seen], p30, 48);
            prob_sums[sites_seen] = s;
            ps = (longint'(stat) << 14) * step;
            pu = (longint'(cfg_uniform) >> 2) * step;
            stat_dist_acc = sat_add(stat_dist_acc, ps > s ? ps - s : s - ps, 56);
            unif_dist_acc = sat_add(unif_dist_acc, pu > s ? pu - s : s - pu, 56);
         end
         sites_seen++;
      end else begin
         overflow_sites = 1;
      end
      if (!last)
         return 0;

      lattice = cfg_line ? 2 * cfg_limit + 1 : cfg_limit;
      st = STATUS_OK;
      if (cfg_limit == 0 || lattice > MAX_SITES) st = STATUS_BAD_SIZE;
      else if (overflow_sites || sites_seen != lattice) st = STATUS_MISMATCH;
      else if (cfg_mix && step == 0) st = STATUS_STEP_ZERO;
      res.status = st;
      res.step = step;
      if (st == STATUS_OK) begin
         mean = clamp_s(first_acc, 32);
         am = mean < 0 ? -mean : mean;
         msq = (am * am) >> 20;
         var_v = clamp_s(longint'(second_acc) - longint'(msq), 44);
         res.mean = mean[31:0];
         res.variance = var_v[43:0];
         if (cfg_mix) begin
            lim33 = (64'd1 << 33) - 1;
            tvd_s = stat_dist_acc / step;
            tvd_u = unif_dist_acc / step;
            res.tvd_stat = tvd_s > lim33 ? lim33 : tvd_s;
            res.tvd_unif = tvd_u > lim33 ? lim33 : tvd_u;
         end
      end
      // clear pass state, keep the sums
      sites_seen = 0;
      overflow_sites = 0;
      first_acc = 0;
      second_acc = 0;
      stat_dist_acc = 0;
      unif_dist_acc = 0;
      return 1;
   endfunction

   always @(posedge clock) begin : watch
      moments_type got, want, fresh;
      if (reset) begin
         cfg_line = 1;
         cfg_limit = 1;
         cfg_mix = 0;
         cfg_uniform = 32'hFFFF_FFFF;
         sites_seen = 0;
         overflow_sites = 0;
         first_acc = 0;
         second_acc = 0;
         stat_dist_acc = 0;
         unif_dist_acc = 0;
         foreach (prob_sums[i]) prob_sums[i] = 0;
         owed_moments.delete();
         fail_count = 0;
      end else begin
         // track register writes
         if (csr_write) begin
            case (csr_index)
               CSR_LINE_MODE:  cfg_line = csr_wdata[0];
               CSR_SITE_LIMIT: cfg_limit = csr_wdata[10:0];
               CSR_MIXING:     cfg_mix = csr_wdata[0];
               CSR_UNIFORM:    cfg_uniform = csr_wdata;
               default:        ;
            endcase
         end
         // compare a result transaction against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_step_echo, rsp_mean_position, rsp_position_variance,
                    rsp_tvd_stationary, rsp_tvd_uniform};
            if (owed_moments.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: %p", got);
            end else begin
               want = owed_moments.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("result differs:\n  expected %p\n  actual   %p", want, got);
               end
            end
         end
         // predict from an accepted site transaction
         if (req_valid && !req_stall) begin
            if (fold_site(req_amp0_re, req_amp0_im, req_amp1_re, req_amp1_im,
                          req_stationary_prob, req_walk_step, req_last_site, fresh))
               owed_moments.push_back(fresh);
         end
      end
      results_owed = owed_moments.size();
   end

endmodule

// ----- sim/walk_state_moments_1d_tb.sv -----
// Testbench top of the walk state moments block: stimulus, flow control and verdict.
module walk_state_moments_1d_tb
   import wsm_pkg::*;
();

   localparam int CYCLE_LIMIT = 40_000_000;
   localparam int SETTLE = 100;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = CSR_LINE_MODE;
   logic [31:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_amp0_re = '0;
   logic signed [15:0] req_amp0_im = '0;
   logic signed [15:0] req_amp1_re = '0;
   logic signed [15:0] req_amp1_im = '0;
   logic [15:0]        req_stationary_prob = '0;
   logic [15:0]        req_walk_step = '0;
   logic               req_last_site = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [15:0]        rsp_step_echo;
   logic signed [31:0] rsp_mean_position;
   logic signed [43:0] rsp_position_variance;
   logic [32:0]        rsp_tvd_stationary;
   logic [32:0]        rsp_tvd_uniform;
   int                 fail_count;
   int                 results_owed;

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_asks = 0;
   int holds_done = 0;
   int hold_left = 0;
   int sites_sent = 0;
   int cycles = 0;
   bit        cur_line = 1;
   bit [10:0] cur_limit = 1;

   walk_state_moments_1d dut (.*);
   walk_moments_checker moments_check (.*);

   always #1 clock = ~clock;

   // bound the run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("walk_state_moments_1d: mismatch");
         $finish;
      end
   end

   // result side: random stalls, long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (holds_done != hold_asks) begin
         holds_done <= holds_done + 1;
         hold_left <= 3000;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic int lattice_sites();
      return cur_line ? 2 * cur_limit + 1 : cur_limit;
   endfunction

   // offer one site transaction, with random idle cycles ahead of it
   task automatic drive_site(input logic [15:0] a0r, a0i, a1r, a1i, stat, step,
                             input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_amp0_re <= a0r;
      req_amp0_im <= a0i;
      req_amp1_re <= a1r;
      req_amp1_im <= a1i;
      req_stationary_prob <= stat;
      req_walk_step <= step;
      req_last_site <= last;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sites_sent++;
   endtask

   // one pass: 0 random, 1 most negative amplitudes, 2 zero, 3 per-site random steps
   task automatic run_pass(input int n, input logic [15:0] step, input int style);
      logic [15:0] s;
      for (int i = 0; i < n; i++) begin
         s = (style == 3) ? (($urandom_range(3) == 0) ? 16'd0 : 16'($urandom)) : step;
         case (style)
            1: drive_site(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, s, i == n - 1);
            2: drive_site('0, '0, '0, '0, '0, s, i == n - 1);
            default: drive_site(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), s, i == n - 1);
         endcase
      end
   endtask

   // wait for the block to drain, then write all registers
   task automatic configure(input bit lm, input bit [10:0] lim, input bit mix,
                            input bit [31:0] uni);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (results_owed == 0);
      repeat (SETTLE) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_LINE_MODE;  csr_wdata <= 32'(lm);  @(posedge clock);
      csr_index <= CSR_SITE_LIMIT; csr_wdata <= 32'(lim); @(posedge clock);
      csr_index <= CSR_MIXING;     csr_wdata <= 32'(mix); @(posedge clock);
      csr_index <= CSR_UNIFORM;    csr_wdata <= uni;      @(posedge clock);
      csr_write <= 1'b0;
      cur_line = lm;
      cur_limit = lim;
   endtask

   initial begin : stimulus
      int n, r, walk_len, len;
      bit [10:0] lim;
      logic [15:0] first_step, step;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, then extremes and error cases
      run_pass(3, 16'd4, 0);
      configure(1, 1, 1, 32'h0);
      run_pass(3, 16'd1, 1);
      run_pass(3, 16'd2, 2);
      run_pass(3, 16'd0, 0);
      run_pass(3, 16'd3, 3);
      configure(1, 0, 1, 32'hFFFF_FFFF);
      run_pass(1, 16'd1, 0);
      configure(0, 3, 0, 32'hFFFF_FFFF);
      run_pass(2, 16'd5, 0);
      run_pass(4, 16'hFFFF, 0);
      // largest lattice, cut short
      configure(1, 11'd2047, 1, 32'h0000_0800);
      run_pass(2, 16'd1, 0);

      // random walks in four flow-control phases
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 36 : 73) : 0;
         stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 36 : 73) : 0;
         if (phase == 2) begin
            // hold off results while two passes are offered back to back
            hold_asks++;
            len = (lattice_sites() > 0) ? lattice_sites() : 1;
            run_pass(len, 16'd2, 0);
            run_pass(len, 16'd3, 0);
         end
         n = sites_sent + 500;
         while (sites_sent < n) begin
            lim = ($urandom_range(19) == 0) ? 11'd0 : 11'($urandom_range(1, 6));
            r = $urandom_range(9);
            configure(1'($urandom_range(1)), lim, $urandom_range(3) != 0,
                      r == 0 ? 32'h0 : (r == 1 ? 32'hFFFF_FFFF : $urandom));
            repeat ($urandom_range(1, 3)) begin
               first_step = ($urandom_range(4) == 0) ? 16'($urandom) : 16'd1;
               walk_len = $urandom_range(1, 5);
               for (int k = 0; k < walk_len; k++) begin
                  step = first_step + 16'(k);
                  r = $urandom_range(99);
                  if (r < 8) begin
                     len = lattice_sites() + int'($urandom_range(2)) + 1 - (r < 4 ? 3 : 0);
                     run_pass(len > 0 ? len : 1, step, 0);
                  end else if (r < 12)
                     run_pass(lattice_sites() > 0 ? lattice_sites() : 1, step, 3);
                  else if (r == 12)
                     run_pass(lattice_sites() > 0 ? lattice_sites() : 1, 16'd0, 0);
                  else
                     run_pass(lattice_sites() > 0 ? lattice_sites() : 1, step, 0);
               end
            end
         end
      end

      // drain and give the verdict
      req_valid <= 1'b0;
      @(posedge clock);
      wait (results_owed == 0);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && results_owed == 0)
         $display("walk_state_moments_1d: match");
      else
         $display("walk_state_moments_1d: mismatch");
      $finish;
   end

endmodule
